>>> hdl/i2cm_pkg.sv
// Shared types and codes for the I2C register access master.
package i2cm_pkg;

    // Command codes carried in the op field of an input beat
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Slave acknowledge report codes
    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // Reset value of the half-bit delay register
    localparam logic [15:0] DELAY_RESET = 16'd5;

    // One input beat
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] slv_addr;
        logic [7:0] reg_index;
        logic [7:0] length;
        logic [7:0] wr_data;
        logic       sda_in;
    } i2cm_in_t;

    // One result beat
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       wr_data_taken;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       rd_last;
        logic [1:0] ack_seen;
        logic       done_res;
        logic       rejected;
    } i2cm_res_t;

endpackage

>>> hdl/i2cm_seq.sv
// Bus sequencer: transaction state registers and the per-beat step logic.
module i2cm_seq #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  i2cm_pkg::i2cm_in_t    item,
    input  logic [DELAY_WIDTH-1:0] delay_ticks,
    output i2cm_pkg::i2cm_res_t   res
);
    import i2cm_pkg::*;

    // Bus phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ST_A   = 4'd1;
    localparam logic [3:0] PH_ST_B   = 4'd2;
    localparam logic [3:0] PH_TX_LO  = 4'd3;
    localparam logic [3:0] PH_TX_HI  = 4'd4;
    localparam logic [3:0] PH_ACK_LO = 4'd5;
    localparam logic [3:0] PH_ACK_HI = 4'd6;
    localparam logic [3:0] PH_RX_LO  = 4'd7;
    localparam logic [3:0] PH_RX_HI  = 4'd8;
    localparam logic [3:0] PH_MA_LO  = 4'd9;
    localparam logic [3:0] PH_MA_HI  = 4'd10;
    localparam logic [3:0] PH_SP_A   = 4'd11;
    localparam logic [3:0] PH_SP_B   = 4'd12;
    localparam logic [3:0] PH_SP_C   = 4'd13;
    localparam logic [3:0] PH_RS_LO  = 4'd14;

    // Byte stages of a transaction
    localparam logic [1:0] STG_ADDR_W = 2'd0;
    localparam logic [1:0] STG_REG    = 2'd1;
    localparam logic [1:0] STG_WDATA  = 2'd2;
    localparam logic [1:0] STG_ADDR_R = 2'd3;

    typedef struct packed {
        logic [3:0]             phase;
        logic [DELAY_WIDTH-1:0] dcnt;
        logic [3:0]             bcnt;
        logic [7:0]             sbyte;
        logic [7:0]             ycnt;
        logic [7:0]             ytot;
        logic [6:0]             saddr;
        logic [7:0]             raddr;
        logic                   is_read;
        logic [1:0]             stage;
        logic                   scl;
        logic                   sda;
        logic                   oe;
    } seq_st_t;

    seq_st_t st_reg, st_next;
    seq_st_t st_rst;

    // Enter a phase: restart the delay counter and set the line levels
    function automatic seq_st_t enter_ph(seq_st_t s_in, logic [3:0] p);
        seq_st_t s;
        s       = s_in;
        s.phase = p;
        s.dcnt  = '0;
        unique case (p)
            PH_ST_A:   begin s.scl = 1'b1; s.sda = 1'b1; s.oe = 1'b1; end
            PH_ST_B:   begin s.scl = 1'b1; s.sda = 1'b0; s.oe = 1'b1; end
            PH_RS_LO:  begin s.scl = 1'b0; s.sda = 1'b1; s.oe = 1'b1; end
            PH_TX_LO:  begin s.scl = 1'b0; s.sda = s.sbyte[7]; s.oe = 1'b1; end
            PH_TX_HI:  s.scl = 1'b1;
            PH_ACK_LO: begin s.scl = 1'b0; s.sda = 1'b1; s.oe = 1'b0; end
            PH_ACK_HI: s.scl = 1'b1;
            PH_RX_LO:  begin s.scl = 1'b0; s.sda = 1'b1; s.oe = 1'b0; end
            PH_RX_HI:  s.scl = 1'b1;
            PH_MA_LO: begin
                s.scl = 1'b0;
                s.sda = (({1'b0, s.ycnt} + 9'd1) >= {1'b0, s.ytot});
                s.oe  = 1'b1;
            end
            PH_MA_HI:  s.scl = 1'b1;
            PH_SP_A:   begin s.scl = 1'b0; s.sda = 1'b0; s.oe = 1'b1; end
            PH_SP_B:   begin s.scl = 1'b1; s.sda = 1'b0; s.oe = 1'b1; end
            default: begin
                s.phase = PH_IDLE; s.scl = 1'b1; s.sda = 1'b1; s.oe = 1'b1;
            end
        endcase
        return s;
    endfunction

    // Load a byte for transmission
    function automatic seq_st_t send_byte(seq_st_t s_in, logic [7:0] b);
        seq_st_t s;
        s       = s_in;
        s.sbyte = b;
        s.bcnt  = '0;
        return enter_ph(s, PH_TX_LO);
    endfunction

    // Clear the shifter and start receiving a byte
    function automatic seq_st_t start_rx(seq_st_t s_in);
        seq_st_t s;
        s       = s_in;
        s.sbyte = '0;
        s.bcnt  = '0;
        return enter_ph(s, PH_RX_LO);
    endfunction

    logic [DELAY_WIDTH-1:0] d_eff;
    logic [DELAY_WIDTH-1:0] dcnt_inc;

    assign d_eff    = (delay_ticks == '0) ? {{(DELAY_WIDTH-1){1'b0}}, 1'b1} : delay_ticks;
    assign dcnt_inc = st_reg.dcnt + {{(DELAY_WIDTH-1){1'b0}}, 1'b1};

    // Reset state: bus idle with both lines high and driven
    always_comb begin
        st_rst       = '0;
        st_rst.phase = PH_IDLE;
        st_rst.scl   = 1'b1;
        st_rst.sda   = 1'b1;
        st_rst.oe    = 1'b1;
    end

    // One step of the sequencer per beat
    always_comb begin
        seq_st_t s;
        s   = st_reg;
        res = '0;
        if (item.op == OP_WRITE || item.op == OP_READ) begin
            if (st_reg.phase != PH_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                s.saddr   = item.slv_addr;
                s.raddr   = item.reg_index;
                s.ytot    = item.length;
                s.ycnt    = '0;
                s.is_read = (item.op == OP_READ);
                s.stage   = STG_ADDR_W;
                s         = enter_ph(s, PH_ST_A);
            end
        end else if (st_reg.phase != PH_IDLE) begin
            s.dcnt = dcnt_inc;
            if (dcnt_inc >= d_eff) begin
                unique case (st_reg.phase)
                    PH_RS_LO:  s = enter_ph(s, PH_ST_A);
                    PH_ST_A:   s = enter_ph(s, PH_ST_B);
                    PH_ST_B:   s = send_byte(s, {s.saddr, (s.stage == STG_ADDR_R)});
                    PH_TX_LO:  s = enter_ph(s, PH_TX_HI);
                    PH_TX_HI: begin
                        s.sbyte = {s.sbyte[6:0], 1'b0};
                        s.bcnt  = s.bcnt + 4'd1;
                        s = (s.bcnt >= 4'd8) ? enter_ph(s, PH_ACK_LO) : enter_ph(s, PH_TX_LO);
                    end
                    PH_ACK_LO: s = enter_ph(s, PH_ACK_HI);
                    PH_ACK_HI: begin
                        res.ack_seen = item.sda_in ? ACK_NACK : ACK_ACK;
                        unique case (s.stage)
                            STG_ADDR_W: begin
                                s.stage = STG_REG;
                                s = send_byte(s, s.raddr);
                            end
                            STG_REG: begin
                                if (s.is_read) begin
                                    s.stage = STG_ADDR_R;
                                    s = enter_ph(s, PH_RS_LO);
                                end else if (s.ytot == '0) begin
                                    s = enter_ph(s, PH_SP_A);
                                end else begin
                                    s.stage = STG_WDATA;
                                    s.ycnt  = '0;
                                    res.wr_data_taken = 1'b1;
                                    s = send_byte(s, item.wr_data);
                                end
                            end
                            STG_WDATA: begin
                                s.ycnt = s.ycnt + 8'd1;
                                if (s.ycnt >= s.ytot) begin
                                    s = enter_ph(s, PH_SP_A);
                                end else begin
                                    res.wr_data_taken = 1'b1;
                                    s = send_byte(s, item.wr_data);
                                end
                            end
                            default: begin
                                s.ycnt = '0;
                                s = (s.ytot == '0) ? enter_ph(s, PH_SP_A) : start_rx(s);
                            end
                        endcase
                    end
                    PH_RX_LO:  s = enter_ph(s, PH_RX_HI);
                    PH_RX_HI: begin
                        s.sbyte = {s.sbyte[6:0], item.sda_in};
                        s.bcnt  = s.bcnt + 4'd1;
                        if (s.bcnt >= 4'd8) begin
                            res.rd_valid = 1'b1;
                            res.rd_data  = s.sbyte;
                            res.rd_last  = (({1'b0, s.ycnt} + 9'd1) >= {1'b0, s.ytot});
                            s = enter_ph(s, PH_MA_LO);
                        end else begin
                            s = enter_ph(s, PH_RX_LO);
                        end
                    end
                    PH_MA_LO:  s = enter_ph(s, PH_MA_HI);
                    PH_MA_HI: begin
                        s.ycnt = s.ycnt + 8'd1;
                        s = (s.ycnt >= s.ytot) ? enter_ph(s, PH_SP_A) : start_rx(s);
                    end
                    PH_SP_A:   s = enter_ph(s, PH_SP_B);
                    PH_SP_B: begin
                        // raise SDA while SCL is high: the STOP condition
                        s.scl   = 1'b1;
                        s.sda   = 1'b1;
                        s.oe    = 1'b1;
                        s.phase = PH_SP_C;
                        s.dcnt  = '0;
                    end
                    default: begin
                        res.done_res = 1'b1;
                        s = enter_ph(s, PH_IDLE);
                    end
                endcase
            end
        end
        st_next = s;

        // Line levels after this beat
        res.scl_out   = s.scl;
        res.sda_out   = s.oe ? s.sda : 1'b1;
        res.sda_drive = s.oe;
        res.busy_res  = (s.phase != PH_IDLE);
    end

    // State update on each processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= st_rst;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

endmodule

>>> hdl/i2c_register_access_master.sv
// Top level of the I2C register access master: beat registers, delay register, sequencer.
//
//  channel | ports                      | direction | content
//  --------+----------------------------+-----------+--------------------------------
//  input   | s_valid s_ready s_item     | in        | tick or begin command, SDA sample
//  result  | m_valid m_ready m_res      | out       | line levels, status, read byte
//  config  | cfg_valid cfg_ready cfg_data | in      | half-bit delay in ticks
//
// Each input beat is captured in an input register and then processed into the
// result register, so one beat per cycle is sustained while the result is not
// stalled. The step logic is the phase sequencer, one small step per beat. A
// stalled result holds the input register, which then backpressures s_ready.
// Reset sets the bus lines high and idle and the delay register to 5;
// cfg_ready is always high.
module i2c_register_access_master #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2cm_pkg::i2cm_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cm_pkg::i2cm_res_t m_res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import i2cm_pkg::*;

    logic                   in_vld_reg;
    i2cm_in_t               in_reg;
    logic                   out_vld_reg;
    i2cm_res_t              out_reg;
    logic [DELAY_WIDTH-1:0] delay_reg;
    logic [DELAY_WIDTH-1:0] delay_next;
    logic [DELAY_WIDTH-1:0] delay_rst;
    logic [47:0]            cfg_ext;
    logic [47:0]            rst_ext;
    logic                   fire;
    i2cm_res_t              step_res;

    // Process a beat when the result slot is free or draining
    assign fire      = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_res     = out_reg;

    // Fit the 16-bit register value to the delay counter width
    assign cfg_ext    = {32'd0, cfg_data};
    assign rst_ext    = {32'd0, DELAY_RESET};
    assign delay_next = cfg_ext[DELAY_WIDTH-1:0];
    assign delay_rst  = rst_ext[DELAY_WIDTH-1:0];

    i2cm_seq #(
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (fire),
        .item        (in_reg),
        .delay_ticks (delay_reg),
        .res         (step_res)
    );

    // Input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    // Result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= step_res;
        end
    end

    // Delay register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= delay_rst;
        end else if (cfg_valid && cfg_ready) begin
            delay_reg <= delay_next;
        end
    end

    // An idle bus keeps both lines high and driven
    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_res.busy_res |-> m_res.scl_out && m_res.sda_out && m_res.sda_drive)
        else $error("idle result with bus lines not released high");

    // A rejected command only happens while a transaction runs
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.rejected |-> m_res.busy_res)
        else $error("command rejected while idle");

    // After a byte is received the master drives its acknowledge with SCL low
    a_rx_master_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.rd_valid |-> m_res.sda_drive && !m_res.scl_out)
        else $error("received byte without master acknowledge phase");

    // A stalled result holds the pending input beat back
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |=> in_vld_reg && $stable(in_reg))
        else $error("pending input beat lost during result stall");

endmodule
